// ===== hw/rtl/bbc_pkg.sv =====
// Shared types, character constants and bracket decode functions for the
// bracket balance checker. No dependencies.
package bbc_pkg;

    localparam int STACK_DEPTH = 8;

    localparam logic [7:0] CH_LPAREN = 8'h28;  // (
    localparam logic [7:0] CH_RPAREN = 8'h29;  // )
    localparam logic [7:0] CH_LSQ    = 8'h5B;  // [
    localparam logic [7:0] CH_RSQ    = 8'h5D;  // ]
    localparam logic [7:0] CH_LBRACE = 8'h7B;  // {
    localparam logic [7:0] CH_RBRACE = 8'h7D;  // }

    typedef logic [1:0] t_code;

    localparam t_code CODE_NONE  = 2'd0;
    localparam t_code CODE_PAREN = 2'd1;
    localparam t_code CODE_SQ    = 2'd2;
    localparam t_code CODE_BRACE = 2'd3;

    // Shift command broadcast to every stack cell
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_cell_ctl;

    function automatic t_code open_code(input logic [7:0] c);
        t_code r;
        case (c)
            CH_LPAREN: r = CODE_PAREN;
            CH_LSQ:    r = CODE_SQ;
            CH_LBRACE: r = CODE_BRACE;
            default:   r = CODE_NONE;
        endcase
        return r;
    endfunction

    function automatic t_code close_code(input logic [7:0] c);
        t_code r;
        case (c)
            CH_RPAREN: r = CODE_PAREN;
            CH_RSQ:    r = CODE_SQ;
            CH_RBRACE: r = CODE_BRACE;
            default:   r = CODE_NONE;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/bbc_if.sv =====
// Valid/ready channel interfaces for the symbol input and the result output.
// Depends on nothing.
interface bbc_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface bbc_res_if;
    logic valid;
    logic ready;
    logic balanced;

    modport source (output valid, output balanced, input ready);
    modport sink   (input valid, input balanced, output ready);
endinterface

// ===== hw/rtl/bracket_balance_checker.sv =====
// Bracket balance checker: takes one character per cycle, back to back, and
// on the character flagged last returns one word, balanced, through a result
// register; the input stalls only while that word is held back by a sink
// that is not ready.
// The bracket stack is a row of STACK_DEPTH shifting cells with the top in the
// first cell, so each character touches only the top and a single shift.
// Pushes onto a full stack are dropped. Uses bbc_pkg, bbc_if and bbc_cell.
module bracket_balance_checker
    import bbc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    bbc_sym_if.sink  i_sym,
    bbc_res_if.source o_res
);

    typedef enum logic [1:0] {
        MODE_FREE  = 2'd0,
        MODE_PAREN = 2'd1,
        MODE_BRACE = 2'd2
    } t_mode;

    t_mode r_mode;
    logic  r_failed;
    logic  r_at_start;
    logic  r_out_valid;
    logic  r_balanced;

    logic  n_failed;
    logic  n_balanced;

    t_cell_ctl             w_ctl;
    t_code                 w_code [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] w_occ;
    logic [STACK_DEPTH:0]   w_occ_ext;

    logic  w_accept;
    t_code w_open;
    t_code w_close;
    logic  w_empty;
    logic  w_full;
    logic  w_square;
    logic  w_brace;
    logic  w_mode_fail;
    logic  w_empty_fail;
    logic  w_match_fail;
    logic  w_empty_after;

    assign i_sym.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_sym.valid && i_sym.ready;

    assign w_open    = open_code(i_sym.symbol);
    assign w_close   = close_code(i_sym.symbol);
    assign w_occ_ext = {1'b0, w_occ};
    assign w_empty   = !w_occ[0];
    assign w_full    = w_occ[STACK_DEPTH-1];

    assign w_square = (i_sym.symbol == CH_LSQ) || (i_sym.symbol == CH_RSQ);
    assign w_brace  = (i_sym.symbol == CH_LBRACE) || (i_sym.symbol == CH_RBRACE);

    assign w_mode_fail  = !r_at_start &&
                          (((r_mode == MODE_PAREN) && (w_square || w_brace)) ||
                           ((r_mode == MODE_BRACE) && w_square));
    // anything but an opener on an empty stack fails, non-brackets included
    assign w_empty_fail = (w_open == CODE_NONE) && w_empty;
    assign w_match_fail = (w_close != CODE_NONE) && !w_empty && (w_code[0] != w_close);

    assign n_failed = r_failed || w_mode_fail || w_empty_fail || w_match_fail;

    assign w_ctl.push  = w_accept && (w_open != CODE_NONE) && !w_full;
    assign w_ctl.pop   = w_accept && (w_close != CODE_NONE) && !w_empty;
    assign w_ctl.clear = w_accept && i_sym.last;

    always_comb begin
        if (w_open != CODE_NONE) begin
            w_empty_after = 1'b0;
        end else if ((w_close != CODE_NONE) && !w_empty) begin
            w_empty_after = !w_occ_ext[1];
        end else begin
            w_empty_after = w_empty;
        end
    end

    assign n_balanced = !n_failed && w_empty_after;

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        t_code w_up_code;
        logic  w_up_occ;
        t_code w_down_code;
        logic  w_down_occ;

        if (g == 0) begin : g_top
            assign w_up_code = w_open;
            assign w_up_occ  = 1'b1;
        end else begin : g_mid
            assign w_up_code = w_code[g-1];
            assign w_up_occ  = w_occ[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_bottom
            assign w_down_code = CODE_NONE;
            assign w_down_occ  = 1'b0;
        end else begin : g_inner
            assign w_down_code = w_code[g+1];
            assign w_down_occ  = w_occ[g+1];
        end

        bbc_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_up_code   (w_up_code),
            .i_up_occ    (w_up_occ),
            .i_down_code (w_down_code),
            .i_down_occ  (w_down_occ),
            .o_code      (w_code[g]),
            .o_occ       (w_occ[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_FREE;
            r_failed    <= 1'b0;
            r_at_start  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                if (i_sym.last) begin
                    r_mode     <= MODE_FREE;
                    r_failed   <= 1'b0;
                    r_at_start <= 1'b1;
                end else begin
                    r_failed   <= n_failed;
                    r_at_start <= 1'b0;
                    if (r_at_start) begin
                        if (i_sym.symbol == CH_LPAREN) begin
                            r_mode <= MODE_PAREN;
                        end else if (i_sym.symbol == CH_LBRACE) begin
                            r_mode <= MODE_BRACE;
                        end else begin
                            r_mode <= MODE_FREE;
                        end
                    end
                end
            end
            if (w_accept && i_sym.last) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_sym.last) begin
            r_balanced <= n_balanced;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.balanced = r_balanced;

`ifndef NO_ASSERTIONS
    // occupied cells always form a run starting at the top cell
    a_occ_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_occ + 1'b1) & w_occ) == '0)
        else $error("stack occupancy not contiguous");

    // end of string leaves an empty stack, fresh start and a pending word
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_sym.last) |=> (o_res.valid && (w_occ == '0) && r_at_start
                                      && !r_failed))
        else $error("string end did not clear state");

    // a latched failure can never report balanced
    a_fail_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_sym.last && r_failed) |=> !o_res.balanced)
        else $error("failed string reported balanced");
`endif

endmodule

// ===== hw/rtl/bbc_cell.sv =====
// One stack entry of the shifting bracket stack: a type code and an occupied
// flag. Takes from the upper neighbor on push, from the lower one on pop. Uses bbc_pkg.
module bbc_cell
    import bbc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_code     i_up_code,
    input  logic      i_up_occ,
    input  t_code     i_down_code,
    input  logic      i_down_occ,
    output t_code     o_code,
    output logic      o_occ
);

    t_code r_code;
    logic  r_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_ctl.clear) begin
            r_occ <= 1'b0;
        end else if (i_ctl.push) begin
            r_occ <= i_up_occ;
        end else if (i_ctl.pop) begin
            r_occ <= i_down_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_code <= i_up_code;
        end else if (i_ctl.pop) begin
            r_code <= i_down_code;
        end
    end

    assign o_code = r_code;
    assign o_occ  = r_occ;

endmodule
